// ----- hdl/rbst_pkg.sv -----
// ----------------------------------------------------------------------------
// rbst_pkg
// shared constants and helpers for the ray versus box slab test
// ----------------------------------------------------------------------------
package rbst_pkg;

	localparam int DEF_COORD_WIDTH = 32;
	localparam int DEF_FRAC_BITS   = 16;
	localparam int QUEUE_DEPTH     = 2;

	// first, last, two magnitudes with signs, direction magnitude with sign, t_lo, t_hi
	function automatic int entry_width(input int w);
		return 5 * w + 5;
	endfunction

endpackage

// ----- hdl/rbst_fifo.sv -----
// ----------------------------------------------------------------------------
// rbst_fifo
// small show-ahead queue: one push per cycle unless full, one pop unless empty
// ----------------------------------------------------------------------------
module rbst_fifo #(
	parameter int DW    = 8,
	parameter int DEPTH = 2
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  logic [DW-1:0] wdata,
	output logic          full,
	input  logic          pop,
	output logic [DW-1:0] rdata,
	output logic          empty
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [DW-1:0] mem_q [DEPTH];
	logic [AW-1:0] wp_q;
	logic [AW-1:0] rp_q;
	logic [AW:0]   cnt_q;
	logic          do_push;
	logic          do_pop;

	assign full    = (cnt_q == (AW+1)'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wp_q <= (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
			end
			if (do_pop) begin
				rp_q <= (rp_q == AW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wp_q] <= wdata;
		end
	end

endmodule

// ----- hdl/rbst_front.sv -----
// ----------------------------------------------------------------------------
// rbst_front
// takes axis items, forms slab offsets and magnitudes, queues them for the back
// ----------------------------------------------------------------------------
module rbst_front #(
	parameter int W = 32,
	parameter int F = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                push,
	output logic                                full,
	input  logic                                first_axis,
	input  logic                                last_axis,
	input  logic signed [W-1:0]                 slab_min,
	input  logic signed [W-1:0]                 slab_max,
	input  logic signed [W-1:0]                 ray_origin,
	input  logic signed [W-1:0]                 ray_dir,
	input  logic signed [W-1:0]                 t_lo,
	input  logic signed [W-1:0]                 t_hi,
	input  logic                                wq_pop,
	output logic                                wq_empty,
	output logic [rbst_pkg::entry_width(W)-1:0] wq_data
);
	import rbst_pkg::*;

	localparam int EW = entry_width(W);

	typedef struct packed {
		logic         first;
		logic         last;
		logic [W-1:0] mag_min;
		logic         neg_min;
		logic [W-1:0] mag_max;
		logic         neg_max;
		logic [W-1:0] dmag;
		logic         dneg;
		logic [W-1:0] t_lo;
		logic [W-1:0] t_hi;
	} entry_t;

	logic [W:0]    diff_min;
	logic [W:0]    diff_max;
	logic [W:0]    abs_min;
	logic [W:0]    abs_max;
	logic [W-1:0]  abs_dir;
	entry_t        cls;
	logic [EW-1:0] cls_vec;

	assign diff_min = {slab_min[W-1], slab_min} - {ray_origin[W-1], ray_origin};
	assign diff_max = {slab_max[W-1], slab_max} - {ray_origin[W-1], ray_origin};
	assign abs_min  = diff_min[W] ? (W+1)'(0) - diff_min : diff_min;
	assign abs_max  = diff_max[W] ? (W+1)'(0) - diff_max : diff_max;
	assign abs_dir  = ray_dir[W-1] ? W'(0) - ray_dir : ray_dir;

	always_comb begin
		cls.first   = first_axis;
		cls.last    = last_axis;
		cls.mag_min = abs_min[W-1:0];
		cls.neg_min = diff_min[W];
		cls.mag_max = abs_max[W-1:0];
		cls.neg_max = diff_max[W];
		cls.dmag    = abs_dir;
		cls.dneg    = ray_dir[W-1];
		cls.t_lo    = t_lo;
		cls.t_hi    = t_hi;
	end

	assign cls_vec = cls;

	rbst_fifo #(
		.DW    (EW),
		.DEPTH (QUEUE_DEPTH)
	) u_work_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (cls_vec),
		.full   (full),
		.pop    (wq_pop),
		.rdata  (wq_data),
		.empty  (wq_empty)
	);

endmodule

// ----- hdl/rbst_div.sv -----
// ----------------------------------------------------------------------------
// rbst_div
// radix-2 restoring divider for saturated fixed point crossing distances
// ----------------------------------------------------------------------------
module rbst_div #(
	parameter int W = 32,
	parameter int F = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] num_mag,
	input  logic         num_neg,
	input  logic [W-1:0] den_mag,
	input  logic         den_neg,
	output logic         done,
	output logic [W-1:0] quot
);
	localparam int NW = W + F + 1;
	localparam int CW = $clog2(W + 1);

	typedef enum logic [1:0] {D_IDLE, D_RUN, D_FIN} dstate_t;

	dstate_t       state_q;
	logic [CW-1:0] cnt_q;
	logic          done_q;
	logic [W-1:0]  rem_q;
	logic [W-1:0]  num_q;
	logic [W-1:0]  quo_q;
	logic [W-1:0]  den_q;
	logic [W-1:0]  res_q;
	logic          qneg_q;
	logic          big_q;

	logic [NW-1:0] dividend;
	logic [NW-1:0] hi_part;
	logic          big;
	logic [W:0]    rem_sh;
	logic [W:0]    rem_sub;
	logic          take;
	logic [W-1:0]  pos_max;
	logic [W-1:0]  neg_full;
	logic [W-1:0]  limit;
	logic [W-1:0]  sat_mag;
	logic          special;

	assign dividend = NW'(num_mag) << F;
	assign hi_part  = dividend >> W;
	assign big      = hi_part >= NW'(den_mag);
	assign special  = (num_mag == '0) || (den_mag == '0);
	assign rem_sh   = {rem_q, num_q[W-1]};
	assign take     = rem_sh >= {1'b0, den_q};
	assign rem_sub  = rem_sh - {1'b0, den_q};
	assign pos_max  = {1'b0, {(W-1){1'b1}}};
	assign neg_full = {1'b1, {(W-1){1'b0}}};
	assign limit    = qneg_q ? neg_full : pos_max;
	assign sat_mag  = (big_q || (quo_q > limit)) ? limit : quo_q;
	assign done     = done_q;
	assign quot     = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= D_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				D_IDLE: begin
					if (start) begin
						if (special) begin
							done_q <= 1'b1;
						end else if (big) begin
							state_q <= D_FIN;
						end else begin
							state_q <= D_RUN;
							cnt_q   <= CW'(W);
						end
					end
				end
				D_RUN: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == CW'(1)) begin
						state_q <= D_FIN;
					end
				end
				D_FIN: begin
					done_q  <= 1'b1;
					state_q <= D_IDLE;
				end
				default: begin
					state_q <= D_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			D_IDLE: begin
				if (start) begin
					qneg_q <= num_neg ^ den_neg;
					big_q  <= big;
					rem_q  <= hi_part[W-1:0];
					num_q  <= dividend[W-1:0];
					quo_q  <= '0;
					den_q  <= den_mag;
					if (num_mag == '0) begin
						res_q <= '0;
					end else if (den_mag == '0) begin
						res_q <= num_neg ? neg_full : pos_max;
					end
				end
			end
			D_RUN: begin
				rem_q <= take ? rem_sub[W-1:0] : rem_sh[W-1:0];
				num_q <= num_q << 1;
				quo_q <= {quo_q[W-2:0], take};
			end
			D_FIN: begin
				res_q <= qneg_q ? W'(0) - sat_mag : sat_mag;
			end
			default: begin
			end
		endcase
	end

endmodule

// ----- hdl/rbst_back.sv -----
// ----------------------------------------------------------------------------
// rbst_back
// runs both crossings through the divider, folds the interval, queues results
// ----------------------------------------------------------------------------
module rbst_back #(
	parameter int W = 32,
	parameter int F = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                wq_empty,
	input  logic [rbst_pkg::entry_width(W)-1:0] wq_data,
	output logic                                wq_pop,
	output logic                                empty,
	input  logic                                pop,
	output logic                                hit,
	output logic signed [W-1:0]                 t_entry
);
	import rbst_pkg::*;

	typedef struct packed {
		logic         first;
		logic         last;
		logic [W-1:0] mag_min;
		logic         neg_min;
		logic [W-1:0] mag_max;
		logic         neg_max;
		logic [W-1:0] dmag;
		logic         dneg;
		logic [W-1:0] t_lo;
		logic [W-1:0] t_hi;
	} entry_t;

	typedef enum logic [1:0] {B_IDLE, B_DIV1, B_DIV2, B_FOLD} bstate_t;

	bstate_t      state_q;
	entry_t       head;
	entry_t       entry_q;
	logic [W-1:0] t1_q;
	logic [W-1:0] t2_q;
	logic [W-1:0] entry_acc_q;
	logic [W-1:0] exit_acc_q;

	logic         div_start;
	logic [W-1:0] div_num;
	logic         div_num_neg;
	logic [W-1:0] div_den;
	logic         div_den_neg;
	logic         div_done;
	logic [W-1:0] div_quot;

	logic [W-1:0] near_t;
	logic [W-1:0] far_t;
	logic [W-1:0] ent0;
	logic [W-1:0] ext0;
	logic [W-1:0] ent;
	logic [W-1:0] ext;
	logic         hit_now;
	logic         fold_go;
	logic         rq_push;
	logic         rq_full;
	logic [W:0]   rq_wdata;
	logic [W:0]   rq_rdata;

	assign head   = entry_t'(wq_data);
	assign wq_pop = (state_q == B_IDLE) && !wq_empty;

	always_comb begin
		if (state_q == B_IDLE) begin
			div_start   = !wq_empty;
			div_num     = head.mag_min;
			div_num_neg = head.neg_min;
			div_den     = head.dmag;
			div_den_neg = head.dneg;
		end else begin
			div_start   = (state_q == B_DIV1) && div_done;
			div_num     = entry_q.mag_max;
			div_num_neg = entry_q.neg_max;
			div_den     = entry_q.dmag;
			div_den_neg = entry_q.dneg;
		end
	end

	rbst_div #(
		.W (W),
		.F (F)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.num_mag (div_num),
		.num_neg (div_num_neg),
		.den_mag (div_den),
		.den_neg (div_den_neg),
		.done    (div_done),
		.quot    (div_quot)
	);

	assign near_t  = ($signed(t2_q) >= $signed(t1_q)) ? t1_q : t2_q;
	assign far_t   = ($signed(t2_q) >= $signed(t1_q)) ? t2_q : t1_q;
	assign ent0    = entry_q.first ? entry_q.t_lo : entry_acc_q;
	assign ext0    = entry_q.first ? entry_q.t_hi : exit_acc_q;
	assign ent     = ($signed(near_t) >= $signed(ent0)) ? near_t : ent0;
	assign ext     = ($signed(ext0) >= $signed(far_t)) ? far_t : ext0;
	assign hit_now = ($signed(ext) >= $signed(ent)) && !ext[W-1];
	assign fold_go = (state_q == B_FOLD) && (!entry_q.last || !rq_full);
	assign rq_push = fold_go && entry_q.last;
	assign rq_wdata = {hit_now, ent};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			entry_acc_q <= '0;
			exit_acc_q  <= '0;
		end else begin
			unique case (state_q)
				B_IDLE: begin
					if (!wq_empty) begin
						state_q <= B_DIV1;
					end
				end
				B_DIV1: begin
					if (div_done) begin
						state_q <= B_DIV2;
					end
				end
				B_DIV2: begin
					if (div_done) begin
						state_q <= B_FOLD;
					end
				end
				B_FOLD: begin
					if (fold_go) begin
						entry_acc_q <= ent;
						exit_acc_q  <= ext;
						state_q     <= B_IDLE;
					end
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (wq_pop) begin
			entry_q <= head;
		end
		if ((state_q == B_DIV1) && div_done) begin
			t1_q <= div_quot;
		end
		if ((state_q == B_DIV2) && div_done) begin
			t2_q <= div_quot;
		end
	end

	rbst_fifo #(
		.DW    (W + 1),
		.DEPTH (QUEUE_DEPTH)
	) u_result_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (rq_push),
		.wdata  (rq_wdata),
		.full   (rq_full),
		.pop    (pop),
		.rdata  (rq_rdata),
		.empty  (empty)
	);

	assign hit     = rq_rdata[W];
	assign t_entry = rq_rdata[W-1:0];

endmodule

// ----- hdl/ray_box_slab_test_top.sv -----
// ----------------------------------------------------------------------------
// ray_box_slab_test_top
// ray versus axis-aligned box slab test, one axis per item, signed fixed point
// an item runs its two quotients in turn through one radix-2 divider in the back end,
// which takes the next item from the work queue only after it has folded the last;
// zero, divide-by-zero and overflowing quotients skip the bit-by-bit divider steps
// reset clears both queues, the sequencer and the entry and exit accumulators
// ----------------------------------------------------------------------------
module ray_box_slab_test_top #(
	parameter int COORD_WIDTH = rbst_pkg::DEF_COORD_WIDTH,
	parameter int FRAC_BITS   = rbst_pkg::DEF_FRAC_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic                          first_axis,
	input  logic                          last_axis,
	input  logic signed [COORD_WIDTH-1:0] slab_min,
	input  logic signed [COORD_WIDTH-1:0] slab_max,
	input  logic signed [COORD_WIDTH-1:0] ray_origin,
	input  logic signed [COORD_WIDTH-1:0] ray_dir,
	input  logic signed [COORD_WIDTH-1:0] t_lo,
	input  logic signed [COORD_WIDTH-1:0] t_hi,
	output logic                          empty,
	input  logic                          pop,
	output logic                          hit,
	output logic signed [COORD_WIDTH-1:0] t_entry
);
	import rbst_pkg::*;

	localparam int EW = entry_width(COORD_WIDTH);

	logic          wq_pop;
	logic          wq_empty;
	logic [EW-1:0] wq_data;

	rbst_front #(
		.W (COORD_WIDTH),
		.F (FRAC_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.first_axis (first_axis),
		.last_axis  (last_axis),
		.slab_min   (slab_min),
		.slab_max   (slab_max),
		.ray_origin (ray_origin),
		.ray_dir    (ray_dir),
		.t_lo       (t_lo),
		.t_hi       (t_hi),
		.wq_pop     (wq_pop),
		.wq_empty   (wq_empty),
		.wq_data    (wq_data)
	);

	rbst_back #(
		.W (COORD_WIDTH),
		.F (FRAC_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.wq_empty (wq_empty),
		.wq_data  (wq_data),
		.wq_pop   (wq_pop),
		.empty    (empty),
		.pop      (pop),
		.hit      (hit),
		.t_entry  (t_entry)
	);

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		wq_pop |-> !wq_empty)
		else $error("work queue popped while empty");

	a_full_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(full && !wq_pop) |=> full)
		else $error("work queue lost an entry without a pop");

	a_pop_frees: assert property (@(posedge clk) disable iff (!arst_n)
		wq_pop |=> !full)
		else $error("work queue full right after a pop");

endmodule
